[design/cfcf_pkg.sv]
// ----------------------------------------------------------------------------
// cfcf_pkg
// Shared types, constants and helpers of the CAN frame change filter.
// ----------------------------------------------------------------------------
package cfcf_pkg;

   // table size default
   localparam int TABLE_ENTRIES_DEF = 32;

   // field widths
   localparam int ID_W   = 29;
   localparam int LEN_W  = 4;
   localparam int DATA_W = 64;
   localparam int TIME_W = 32;

   // stream and register port widths
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_REPRINT_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_ENABLE    = 1'd1;

   // register reset values
   localparam logic [TIME_W-1:0] REPRINT_INTERVAL_RESET = 32'd500;
   localparam logic              FILTER_ENABLE_RESET    = 1'b1;

   // result cause codes
   typedef enum logic [2:0] {
      CAUSE_SUPPRESSED = 3'd0,
      CAUSE_NEW        = 3'd1,
      CAUSE_CHANGED    = 3'd2,
      CAUSE_INTERVAL   = 3'd3,
      CAUSE_TABLE_FULL = 3'd4,
      CAUSE_FILTER_OFF = 3'd5
   } cause_type;

   // configuration seen by the engine
   typedef struct packed {
      logic [TIME_W-1:0] reprint_interval_ms;
      logic              change_filter_enable;
   } cfg_type;

   // one received frame
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [DATA_W-1:0] frame_data;
      logic [LEN_W-1:0]  frame_len;
      logic [ID_W-1:0]   frame_id;
   } item_type;

   // one result
   typedef struct packed {
      cause_type cause;
      logic      show_frame;
   } result_type;

   // one table entry, id in the low bits
   typedef struct packed {
      logic [TIME_W-1:0] entry_time;
      logic [DATA_W-1:0] entry_data;
      logic [LEN_W-1:0]  entry_len;
      logic [ID_W-1:0]   entry_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // mask of the valid data bytes, lengths above eight cover all bytes
   function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [DATA_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < DATA_W / 8; b++) begin
         if (len > LEN_W'(b)) begin
            mask[b*8 +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

[design/can_frame_change_filter.sv]
// ----------------------------------------------------------------------------
// can_frame_change_filter
// Passes a CAN frame only when it is new, changed or due for a repeat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one received frame per item; rsp_ channel returns
//   one result item (show_frame, cause) for every accepted frame, in order.
//   csr_ port writes the reprint interval (index 0) and the filter enable
//   (index 1); it is always ready. The user writes it only while the block idles;
//   the block itself does not enforce this.
// Scan:
//   tracked identifiers live in one entry memory that is scanned one entry
//   per cycle through its registered read port, up to the first matching
//   identifier or the last entry in use. A new frame is taken only after
//   the previous result has moved into the output register; with the
//   filter off the scan is skipped.
// Reset:
//   the fill count clears, so the table is empty; no clearing pass is needed.
//   Registers return to a 500 ms interval with the filter on.
// Stall:
//   a result waits in the output register; the next frame is still taken
//   and scanned, and its result is held until the waiting one is taken.
// ----------------------------------------------------------------------------
module can_frame_change_filter #(
   parameter int TABLE_ENTRIES = cfcf_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // frame_id[28:0], frame_len[32:29], frame_data[96:33], now_ms[128:97], zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cfcf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // show_frame[0], cause[3:1], zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cfcf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cfcf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cfcf_pkg::CSR_DATA_W-1:0]    csr_data
);

   cfcf_pkg::cfg_type    cfg;
   cfcf_pkg::item_type   req_item;
   cfcf_pkg::result_type rsp_result;

   // unpack the frame fields
   assign req_item.frame_id   = req_tdata[28:0];
   assign req_item.frame_len  = req_tdata[32:29];
   assign req_item.frame_data = req_tdata[96:33];
   assign req_item.now_ms     = req_tdata[128:97];

   cfcf_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cfcf_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   // pack the result item
   assign rsp_tdata = {4'b0000, rsp_result.cause, rsp_result.show_frame};

`ifndef ASSERT_OFF
   // only a suppressed frame is hidden
   a_show_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] != 3'(cfcf_pkg::CAUSE_SUPPRESSED))))
      else $error("show_frame disagrees with cause");

   // cause stays within the defined codes
   a_cause_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:1] <= 3'(cfcf_pkg::CAUSE_FILTER_OFF)))
      else $error("undefined cause code");

   // an accepted item keeps the input closed in the next cycle
   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in work");
`endif

endmodule

[design/cfcf_ram.sv]
// ----------------------------------------------------------------------------
// cfcf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cfcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cfcf_regs.sv]
// ----------------------------------------------------------------------------
// cfcf_regs
// Configuration registers: reprint interval and filter enable.
// ----------------------------------------------------------------------------
module cfcf_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cfcf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cfcf_pkg::CSR_DATA_W-1:0]    csr_data,
   output cfcf_pkg::cfg_type                  cfg
);

   cfcf_pkg::cfg_type cfg_ff;
   cfcf_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            cfcf_pkg::REG_REPRINT_INTERVAL: begin
               cfg_in.reprint_interval_ms = csr_data;
            end
            cfcf_pkg::REG_FILTER_ENABLE: begin
               cfg_in.change_filter_enable = csr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reprint_interval_ms  <= cfcf_pkg::REPRINT_INTERVAL_RESET;
         cfg_ff.change_filter_enable <= cfcf_pkg::FILTER_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

[design/cfcf_engine.sv]
// ----------------------------------------------------------------------------
// cfcf_engine
// Table scan, compare and update around the entry memory, plus result register.
// ----------------------------------------------------------------------------
module cfcf_engine #(
   parameter int TABLE_ENTRIES = cfcf_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfcf_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cfcf_pkg::item_type     req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cfcf_pkg::result_type   rsp_result
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [CW-1:0]                      fill_ff, fill_in;
   logic [AW-1:0]                      raddr_ff, raddr_in;
   logic                               rvld_ff, rvld_in;
   logic [AW-1:0]                      ridx_ff, ridx_in;
   cfcf_pkg::item_type                 item_ff, item_in;
   cfcf_pkg::result_type               res_ff, res_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   cfcf_pkg::result_type               rsp_ff, rsp_in;

   logic                               rd_en;
   logic [cfcf_pkg::ENTRY_W-1:0]       rd_data;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   cfcf_pkg::entry_type                wr_entry;
   cfcf_pkg::entry_type                ent;

   logic [cfcf_pkg::DATA_W-1:0]        mask;
   logic [cfcf_pkg::TIME_W-1:0]        age;
   logic                               id_hit;
   logic                               changed;
   logic                               aged;
   logic                               last_idx;
   logic                               miss;
   logic                               full;

   // entry memory
   cfcf_ram #(
      .WIDTH (cfcf_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (raddr_ff),
      .rd_data (rd_data)
   );

   // compare of the entry read in the previous cycle
   assign ent      = rd_data;
   assign mask     = cfcf_pkg::byte_mask(item_ff.frame_len);
   assign age      = item_ff.now_ms - ent.entry_time;
   assign id_hit   = rvld_ff && (ent.entry_id == item_ff.frame_id);
   assign changed  = (ent.entry_len != item_ff.frame_len) ||
                     (((ent.entry_data ^ item_ff.frame_data) & mask) != '0);
   assign aged     = age >= cfg.reprint_interval_ms;
   assign last_idx = (CW'(ridx_ff) == (fill_ff - CW'(1)));
   assign miss     = (fill_ff == '0) || (rvld_ff && !id_hit && last_idx);
   assign full     = (fill_ff == CW'(TABLE_ENTRIES));

   // new contents of an entry
   always_comb begin
      wr_entry.entry_time = item_ff.now_ms;
      wr_entry.entry_data = item_ff.frame_data & mask;
      wr_entry.entry_len  = item_ff.frame_len;
      wr_entry.entry_id   = item_ff.frame_id;
   end

   // control sequence
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      raddr_in     = raddr_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = ridx_ff;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_item;
               raddr_in = '0;
               if (!cfg.change_filter_enable) begin
                  res_in.show_frame = 1'b1;
                  res_in.cause      = cfcf_pkg::CAUSE_FILTER_OFF;
                  state_in          = ST_RESULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // one read per cycle over the filled entries
            rd_en    = (CW'(raddr_ff) < fill_ff);
            raddr_in = raddr_ff + AW'(1);
            if (id_hit) begin
               state_in          = ST_RESULT;
               res_in.show_frame = 1'b1;
               wr_addr           = ridx_ff;
               if (changed) begin
                  wr_en        = 1'b1;
                  res_in.cause = cfcf_pkg::CAUSE_CHANGED;
               end else if (aged) begin
                  wr_en        = 1'b1;
                  res_in.cause = cfcf_pkg::CAUSE_INTERVAL;
               end else begin
                  res_in.show_frame = 1'b0;
                  res_in.cause      = cfcf_pkg::CAUSE_SUPPRESSED;
               end
            end else if (miss) begin
               state_in          = ST_RESULT;
               res_in.show_frame = 1'b1;
               if (full) begin
                  res_in.cause = cfcf_pkg::CAUSE_TABLE_FULL;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = fill_ff[AW-1:0];
                  fill_in      = fill_ff + CW'(1);
                  res_in.cause = cfcf_pkg::CAUSE_NEW;
               end
            end
         end
         ST_RESULT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rvld_in = rd_en;
   assign ridx_in = raddr_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      raddr_ff <= raddr_in;
      ridx_ff  <= ridx_in;
      item_ff  <= item_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

[sim/can_frame_change_filter_chk.sv]
// ----------------------------------------------------------------------------
// can_frame_change_filter_chk
// Watches the frame, result and register channels of the CAN frame change
// filter. It keeps its own copy of the tracked identifier table and the
// registers, works out the verdict for every accepted frame and compares it
// with the result items in order.
// ----------------------------------------------------------------------------
module can_frame_change_filter_chk #(
   parameter int TABLE_ENTRIES = cfcf_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [cfcf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [cfcf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [cfcf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cfcf_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                 mismatch_count,
   output int                                 results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import cfcf_pkg::*;

   // register copies
   logic [TIME_W-1:0] interval_ms;
   logic              filter_on;

   // tracked identifier table
   logic              trk_valid [TABLE_ENTRIES];
   logic [ID_W-1:0]   trk_id    [TABLE_ENTRIES];
   logic [LEN_W-1:0]  trk_len   [TABLE_ENTRIES];
   logic [DATA_W-1:0] trk_data  [TABLE_ENTRIES];
   logic [TIME_W-1:0] trk_time  [TABLE_ENTRIES];

   // verdicts still waiting for their result item
   result_type        verdict_q [$];
   int                errors = 0;

   // bytes that take part in the comparison, at most eight
   function automatic logic [DATA_W-1:0] valid_bytes(input logic [LEN_W-1:0] len);
      int n;
      n = (len > LEN_W'(8)) ? 8 : int'(len);
      if (n == 8) return '1;
      return (DATA_W'(1) << (8 * n)) - DATA_W'(1);
   endfunction

   function automatic void remember_frame(input int k, input item_type f);
      trk_valid[k] = 1'b1;
      trk_id[k]    = f.frame_id;
      trk_len[k]   = f.frame_len;
      trk_data[k]  = f.frame_data & valid_bytes(f.frame_len);
      trk_time[k]  = f.now_ms;
   endfunction

   // verdict for one frame, updates the table copy when the frame is passed as new, changed or aged
   function automatic result_type filter_frame(input item_type f);
      result_type        res;
      logic [DATA_W-1:0] m;
      logic              differs;
      logic              aged;
      res.show_frame = 1'b1;
      res.cause      = CAUSE_FILTER_OFF;
      if (!filter_on) return res;
      m = valid_bytes(f.frame_len);
      // known identifier
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (trk_valid[k] && trk_id[k] == f.frame_id) begin
            differs = (trk_len[k] != f.frame_len) ||
                      ((trk_data[k] & m) != (f.frame_data & m));
            aged    = TIME_W'(f.now_ms - trk_time[k]) >= interval_ms;
            if (differs || aged) begin
               remember_frame(k, f);
               res.cause = differs ? CAUSE_CHANGED : CAUSE_INTERVAL;
            end else begin
               res.show_frame = 1'b0;
               res.cause      = CAUSE_SUPPRESSED;
            end
            return res;
         end
      end
      // new identifier takes the lowest free entry
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (!trk_valid[k]) begin
            remember_frame(k, f);
            res.cause = CAUSE_NEW;
            return res;
         end
      end
      res.cause = CAUSE_TABLE_FULL;
      return res;
   endfunction

   function automatic void log_failure(input string what);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $time, what);
   endfunction

   // track registers, predict per accepted frame, compare per result item
   always @(posedge clock) begin
      item_type   f;
      result_type want;
      result_type got;
      if (reset) begin
         interval_ms = REPRINT_INTERVAL_RESET;
         filter_on   = FILTER_ENABLE_RESET;
         for (int k = 0; k < TABLE_ENTRIES; k++) trk_valid[k] = 1'b0;
         verdict_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REPRINT_INTERVAL: interval_ms = csr_data;
               REG_FILTER_ENABLE:    filter_on   = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            f = req_tdata[$bits(item_type)-1:0];
            verdict_q.push_back(filter_frame(f));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.show_frame = rsp_tdata[0];
            got.cause      = cause_type'(rsp_tdata[3:1]);
            if (verdict_q.size() == 0) begin
               log_failure($sformatf("unexpected result item: show_frame %0b cause %0d",
                                     got.show_frame, got.cause));
            end else begin
               want = verdict_q.pop_front();
               if (got.show_frame !== want.show_frame || got.cause !== want.cause)
                  log_failure($sformatf({"result mismatch: expected show_frame %0b cause %0d,",
                                         " got show_frame %0b cause %0d"},
                                        want.show_frame, want.cause,
                                        got.show_frame, got.cause));
            end
         end
      end
      mismatch_count <= errors;
      results_owed   <= verdict_q.size();
   end

endmodule

[sim/can_frame_change_filter_tb.sv]
// ----------------------------------------------------------------------------
// can_frame_change_filter_tb
// Drives CAN frames into the change filter: a directed run through new,
// unchanged, changed, aged, wrapping and oversized-length frames and the
// register extremes, then random traffic over a pool of identifiers that
// fills the table, under several interval and enable settings, with random
// gaps and stalls on both channels. Checking is done in the checker module.
// ----------------------------------------------------------------------------
module can_frame_change_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfcf_pkg::*;

   localparam int POOL_SIZE   = 40;
   localparam int RUN_LIMIT   = 1_000_000;
   localparam int TAIL_CYCLES = 40;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int                     mismatch_count;
   int                     results_owed;
   int                     cycle_count = 0;

   // stimulus state
   logic [TIME_W-1:0]      stamp_ms;
   bit                     burst_mode;
   logic [ID_W-1:0]        id_pool   [POOL_SIZE];
   bit                     pool_seen [POOL_SIZE];
   logic [LEN_W-1:0]       pool_len  [POOL_SIZE];
   logic [DATA_W-1:0]      pool_data [POOL_SIZE];

   always #5ns clock = ~clock;

   can_frame_change_filter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   can_frame_change_filter_chk u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // watchdog, far above the slowest run (~700 items)
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random ready, two long hold-offs while frames keep coming
   initial begin : rsp_pacing
      int stay;
      int taken;
      int long_holds;
      int r;
      stay       = 0;
      taken      = 0;
      long_holds = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (stay > 0) begin
            stay--;
         end else if ((long_holds == 0 && taken >= 40) ||
                      (long_holds == 1 && taken >= 450)) begin
            long_holds++;
            rsp_tready <= 1'b0;
            stay = 300;
         end else begin
            r = $urandom_range(99);
            if (r < 55) begin
               rsp_tready <= 1'b1;
               stay = $urandom_range(1, 30);
            end else if (r < 92) begin
               rsp_tready <= 1'b0;
               stay = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               stay = $urandom_range(15, 80);
            end
         end
      end
   end

   // gap before a frame: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [LEN_W-1:0] rand_len();
      if ($urandom_range(99) < 15) return LEN_W'($urandom_range(9, 15));
      return LEN_W'($urandom_range(0, 8));
   endfunction

   function automatic logic [TIME_W-1:0] ms_step();
      int r;
      r = $urandom_range(99);
      if (r < 70) return TIME_W'($urandom_range(0, 300));
      if (r < 95) return TIME_W'($urandom_range(300, 1500));
      return TIME_W'($urandom);
   endfunction

   // offer one frame and hold it until taken; valid stays up for the next one
   task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                             input logic [DATA_W-1:0] data, input logic [TIME_W-1:0] now);
      item_type f;
      int       gap;
      f.frame_id   = id;
      f.frame_len  = len;
      f.frame_data = data;
      f.now_ms     = now;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_W'(f);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait until every result item has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      drain();
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly pool identifiers repeating, changing a byte or the length,
   // plus some frames with a fully random identifier
   task automatic send_random_frame();
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
      int                k;
      int                r;
      int                b;
      int                nb;
      r = $urandom_range(99);
      stamp_ms = stamp_ms + ms_step();
      if (r < 8) begin
         id   = ID_W'($urandom);
         len  = LEN_W'($urandom);
         data = {$urandom, $urandom};
      end else begin
         k = $urandom_range(POOL_SIZE - 1);
         if (!pool_seen[k] || r < 22) begin
            len  = rand_len();
            data = {$urandom, $urandom};
         end else begin
            len  = pool_len[k];
            data = pool_data[k];
            nb   = (len > LEN_W'(8)) ? 8 : int'(len);
            if (r < 40 && (nb == 0 || r < 27)) begin
               len = rand_len();
            end else if (r < 40) begin
               b = $urandom_range(nb - 1);
               data[b*8 +: 8] ^= 8'($urandom_range(1, 255));
            end else begin
               // same content, bytes past the length scrambled
               for (b = nb; b < 8; b++) data[b*8 +: 8] = 8'($urandom);
            end
         end
         id           = id_pool[k];
         pool_seen[k] = 1'b1;
         pool_len[k]  = len;
         pool_data[k] = data;
      end
      send_frame(id, len, data, stamp_ms);
   endtask

   task automatic run_random(input int count, input bit no_gaps, input int pause_at);
      burst_mode = no_gaps;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) drain();
         send_random_frame();
      end
      burst_mode = 1'b0;
   endtask

   // stimulus and verdict
   initial begin
      burst_mode = 1'b0;
      stamp_ms   = '0;
      for (int k = 0; k < POOL_SIZE; k++) begin
         id_pool[k]   = ID_W'($urandom);
         pool_seen[k] = 1'b0;
         pool_len[k]  = '0;
         pool_data[k] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset registers: 500 ms interval, filter on
      send_frame(29'h0, 4'd0, '1, 32'd1000);                          // new
      send_frame(29'h0, 4'd0, '0, 32'd1001);                          // empty frame, same
      send_frame(29'h1FFF_FFFF, 4'd8, '1, 32'd1002);                  // new
      send_frame(29'h1FFF_FFFF, 4'd8, '1, 32'd1501);                  // one ms short
      send_frame(29'h1FFF_FFFF, 4'd8, '1, 32'd1502);                  // interval reached
      send_frame(29'h1FFF_FFFF, 4'd8, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1503); // top byte changed
      send_frame(29'h123, 4'd3, 64'hDEAD_BEEF_00AA_BBCC, 32'd1504);   // new
      send_frame(29'h123, 4'd3, 64'h1234_5678_99AA_BBCC, 32'd1505);   // only unused bytes differ
      send_frame(29'h123, 4'd4, 64'h1234_5678_99AA_BBCC, 32'd1506);   // length differs
      send_frame(29'h123, 4'd4, 64'h0, 32'd3000);                     // changed and aged
      send_frame(29'h456, 4'd12, 64'h0123_4567_89AB_CDEF, 32'd3001);  // oversized length
      send_frame(29'h456, 4'd12, 64'h0123_4567_89AB_CDEF, 32'd3002);
      send_frame(29'h456, 4'd8, 64'h0123_4567_89AB_CDEF, 32'd3003);
      send_frame(29'h456, 4'd15, 64'h0123_4567_89AB_CDEF, 32'd3004);
      send_frame(29'h789, 4'd1, 64'h55, 32'hFFFF_FFFF);               // time wraps next
      send_frame(29'h789, 4'd1, 64'h55, 32'h0000_01F2);
      send_frame(29'h789, 4'd1, 64'h55, 32'h0000_01F3);
      // zero interval passes every unchanged frame
      write_reg(REG_REPRINT_INTERVAL, 32'd0);
      send_frame(29'h789, 4'd1, 64'h55, 32'h0000_01F3);
      // largest interval: only an age of all ones qualifies
      write_reg(REG_REPRINT_INTERVAL, 32'hFFFF_FFFF);
      send_frame(29'h789, 4'd1, 64'h55, 32'h0000_01F2);
      send_frame(29'h789, 4'd1, 64'h55, 32'h0000_01F3);
      // filter off leaves the table alone, so the id is new afterwards
      write_reg(REG_FILTER_ENABLE, 32'd0);
      send_frame(29'hABC, 4'd2, 64'hFFFF_0000_1234_A5A5, 32'd0);
      write_reg(REG_FILTER_ENABLE, 32'd1);
      write_reg(REG_REPRINT_INTERVAL, REPRINT_INTERVAL_RESET);
      send_frame(29'hABC, 4'd2, 64'hFFFF_0000_1234_A5A5, 32'd1);

      // random traffic over several register settings
      stamp_ms = TIME_W'($urandom);
      run_random(150, 1'b0, -1);
      write_reg(REG_REPRINT_INTERVAL, 32'd0);
      run_random(100, 1'b1, -1);
      write_reg(REG_REPRINT_INTERVAL, 32'hFFFF_FFFF);
      run_random(100, 1'b0, -1);
      write_reg(REG_FILTER_ENABLE, 32'd0);
      run_random(60, 1'b0, -1);
      write_reg(REG_FILTER_ENABLE, 32'd1);
      write_reg(REG_REPRINT_INTERVAL, CSR_DATA_W'($urandom_range(1, 3000)));
      run_random(130, 1'b0, 60);
      write_reg(REG_REPRINT_INTERVAL, CSR_DATA_W'($urandom_range(50, 800)));
      stamp_ms = 32'hFFFF_F000 + TIME_W'($urandom_range(0, 255));
      run_random(120, 1'b0, -1);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
